### rtl/mep_pkg.sv
// ============================================================================
// mep_pkg
// shared constants, types and the color table of the escape-time colorer
// ============================================================================
package mep_pkg;

    localparam int FRAC_BITS    = 28;
    localparam int COLOR_PERIOD = 51;
    localparam int COORD_W      = 32;
    localparam int PROD_W       = 2 * COORD_W;
    localparam int ITER_W       = 16;
    localparam int CHAN_W       = 8;
    localparam int K_W          = $clog2(COLOR_PERIOD);

    // |z|^2 >= 4 in a product with 2*FRAC_BITS fraction bits
    localparam int ESC_BIT = 2 * FRAC_BITS + 2;

    localparam logic [ITER_W-1:0] MAX_ITER_RESET = ITER_W'(2000);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPD,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic mul;
        logic upd;
        logic fin;
        logic fin_esc;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic at_limit;
        logic escape;
    } t_dp_sts;

    typedef logic [3*CHAN_W-1:0] t_rgb;
    typedef t_rgb [COLOR_PERIOD-1:0] t_color_lut;

    // floor(k/P * max(0, 1 - 4*(k/P - h/2)^2) * 255) with P = COLOR_PERIOD-1,
    // red in the top byte, then green, then blue
    function automatic t_rgb color_entry(int k);
        unique case (k)
            0:  return {8'd0,   8'd0,   8'd0};
            1:  return {8'd0,   8'd0,   8'd5};
            2:  return {8'd0,   8'd1,   8'd10};
            3:  return {8'd0,   8'd3,   8'd15};
            4:  return {8'd0,   8'd6,   8'd19};
            5:  return {8'd0,   8'd9,   8'd24};
            6:  return {8'd0,   8'd12,  8'd28};
            7:  return {8'd0,   8'd17,  8'd32};
            8:  return {8'd0,   8'd21,  8'd36};
            9:  return {8'd0,   8'd27,  8'd39};
            10: return {8'd0,   8'd32,  8'd42};
            11: return {8'd0,   8'd38,  8'd45};
            12: return {8'd0,   8'd44,  8'd47};
            13: return {8'd0,   8'd51,  8'd48};
            14: return {8'd0,   8'd57,  8'd49};
            15: return {8'd0,   8'd64,  8'd48};
            16: return {8'd0,   8'd71,  8'd48};
            17: return {8'd0,   8'd77,  8'd46};
            18: return {8'd0,   8'd84,  8'd44};
            19: return {8'd0,   8'd91,  8'd40};
            20: return {8'd0,   8'd97,  8'd36};
            21: return {8'd0,   8'd104, 8'd31};
            22: return {8'd0,   8'd110, 8'd25};
            23: return {8'd0,   8'd116, 8'd18};
            24: return {8'd0,   8'd122, 8'd9};
            25: return {8'd0,   8'd127, 8'd0};
            26: return {8'd10,  8'd132, 8'd0};
            27: return {8'd21,  8'd136, 8'd0};
            28: return {8'd32,  8'd140, 8'd0};
            29: return {8'd43,  8'd144, 8'd0};
            30: return {8'd55,  8'd146, 8'd0};
            31: return {8'd66,  8'd148, 8'd0};
            32: return {8'd78,  8'd150, 8'd0};
            33: return {8'd90,  8'd151, 8'd0};
            34: return {8'd102, 8'd150, 8'd0};
            35: return {8'd114, 8'd149, 8'd0};
            36: return {8'd126, 8'd148, 8'd0};
            37: return {8'd137, 8'd145, 8'd0};
            38: return {8'd149, 8'd141, 8'd0};
            39: return {8'd160, 8'd136, 8'd0};
            40: return {8'd171, 8'd130, 8'd0};
            41: return {8'd182, 8'd123, 8'd0};
            42: return {8'd192, 8'd115, 8'd0};
            43: return {8'd202, 8'd105, 8'd0};
            44: return {8'd211, 8'd94,  8'd0};
            45: return {8'd220, 8'd82,  8'd0};
            46: return {8'd228, 8'd69,  8'd0};
            47: return {8'd236, 8'd54,  8'd0};
            48: return {8'd243, 8'd37,  8'd0};
            49: return {8'd249, 8'd19,  8'd0};
            50: return {8'd255, 8'd0,   8'd0};
            default: return '0;
        endcase
    endfunction

    function automatic t_color_lut build_color_lut();
        t_color_lut lut;
        for (int k = 0; k < COLOR_PERIOD; k++) begin
            lut[k] = color_entry(k);
        end
        return lut;
    endfunction

    localparam t_color_lut COLOR_LUT = build_color_lut();

endpackage

### rtl/mandelbrot_escape_pixel_color.sv
// ============================================================================
// mandelbrot_escape_pixel_color
// escape-time iteration of one point c, colored through a 51-entry table
// ============================================================================
//
// channel   ports                                   handshake
// -------   -------------------------------------   ---------------------------
// point     i_c_re, i_c_im                          taken when start && !busy
// pixel     o_red, o_green, o_blue, o_escaped,      one-cycle strobe o_valid
//           o_iterations
// config    i_cfg_wdata (max_iterations)            written when i_cfg_we
//
// timing
// - each step of z = z*z + c runs ST_MUL, which registers the three 32x32
//   products, then ST_UPD, which does the escape test and the z update
// - an escaping point finishes from ST_UPD, an inside point from ST_MUL once
//   the step count reaches max_iterations; ST_DONE then raises o_valid
// - busy stays high through the strobe cycle, so the next word can be taken
//   the cycle after o_valid
// - synchronous active-low reset; max_iterations resets to 2000
// - the receiver cannot stall; each pixel word is shown for one cycle only
//
module mandelbrot_escape_pixel_color
    import mep_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [COORD_W-1:0] i_c_re,
    input  logic signed [COORD_W-1:0] i_c_im,
    input  logic                      i_cfg_we,
    input  logic        [ITER_W-1:0]  i_cfg_wdata,
    output logic                      o_valid,
    output logic        [CHAN_W-1:0]  o_red,
    output logic        [CHAN_W-1:0]  o_green,
    output logic        [CHAN_W-1:0]  o_blue,
    output logic                      o_escaped,
    output logic        [ITER_W-1:0]  o_iterations
);

    // iteration limit register
    logic [ITER_W-1:0] r_max_iter;

    // command and status between sequencer and datapath
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= MAX_ITER_RESET;
        end else if (i_cfg_we) begin
            r_max_iter <= i_cfg_wdata;
        end
    end

    // step sequencer
    mep_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    // z arithmetic, counters and output word
    mep_datapath u_dp (
        .i_clk        (i_clk),
        .i_cmd        (w_cmd),
        .i_c_re       (i_c_re),
        .i_c_im       (i_c_im),
        .i_max_iter   (r_max_iter),
        .o_sts        (w_sts),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_escaped    (o_escaped),
        .o_iterations (o_iterations)
    );

    // strobe is a single cycle
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("o_valid held for more than one cycle");

    // an accepted word keeps the block busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_valid))
        else $error("accepted word did not make the block busy");

    // an inside point is black
    a_inside_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_escaped) |-> (o_red == '0 && o_green == '0 && o_blue == '0))
        else $error("non-escaped point has a nonzero color");

    // no step is issued past the limit
    a_step_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.mul |-> (o_iterations < r_max_iter))
        else $error("multiply step issued at or past the iteration limit");

endmodule

### rtl/mep_ctrl.sv
// ============================================================================
// mep_ctrl
// sequencer: alternates multiply and update steps until escape or limit
// ============================================================================
module mep_ctrl
    import mep_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_busy,
    output logic    o_valid
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        o_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MUL;
                end
            end
            ST_MUL: begin
                if (i_sts.at_limit) begin
                    o_cmd.fin = 1'b1;
                    n_state   = ST_DONE;
                end else begin
                    o_cmd.mul = 1'b1;
                    n_state   = ST_UPD;
                end
            end
            ST_UPD: begin
                if (i_sts.escape) begin
                    o_cmd.fin     = 1'b1;
                    o_cmd.fin_esc = 1'b1;
                    n_state       = ST_DONE;
                end else begin
                    o_cmd.upd = 1'b1;
                    n_state   = ST_MUL;
                end
            end
            ST_DONE: begin
                o_valid = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/mep_datapath.sv
// ============================================================================
// mep_datapath
// z registers, product registers, step counters and color output registers
// ============================================================================
module mep_datapath
    import mep_pkg::*;
(
    input  logic                      i_clk,
    input  t_dp_cmd                   i_cmd,
    input  logic signed [COORD_W-1:0] i_c_re,
    input  logic signed [COORD_W-1:0] i_c_im,
    input  logic        [ITER_W-1:0]  i_max_iter,
    output t_dp_sts                   o_sts,
    output logic        [CHAN_W-1:0]  o_red,
    output logic        [CHAN_W-1:0]  o_green,
    output logic        [CHAN_W-1:0]  o_blue,
    output logic                      o_escaped,
    output logic        [ITER_W-1:0]  o_iterations
);

    logic signed [COORD_W-1:0] r_c_re;
    logic signed [COORD_W-1:0] r_c_im;
    logic signed [COORD_W-1:0] r_zr;
    logic signed [COORD_W-1:0] r_zi;
    logic signed [PROD_W-1:0]  r_sr;
    logic signed [PROD_W-1:0]  r_si;
    logic signed [PROD_W-1:0]  r_sx;
    logic        [ITER_W-1:0]  r_iter;
    logic        [K_W-1:0]     r_k;
    logic        [CHAN_W-1:0]  r_red;
    logic        [CHAN_W-1:0]  r_green;
    logic        [CHAN_W-1:0]  r_blue;
    logic                      r_esc;

    logic signed [PROD_W-1:0]  w_sr;
    logic signed [PROD_W-1:0]  w_si;
    logic signed [PROD_W-1:0]  w_sx;
    logic        [PROD_W-1:0]  w_mag;
    logic signed [PROD_W-1:0]  w_diff;
    logic signed [COORD_W-1:0] w_nr;
    logic signed [COORD_W-1:0] w_ni;
    logic        [K_W-1:0]     w_k_next;
    t_rgb                      w_rgb;

    assign w_sr = r_zr * r_zr;
    assign w_si = r_zi * r_zi;
    assign w_sx = r_zr * r_zi;

    // both squares are non-negative, so the sum cannot wrap
    assign w_mag  = PROD_W'(r_sr) + PROD_W'(r_si);
    assign w_diff = r_sr - r_si;

    // floor shift then wrap to 32 bits is just a bit slice
    assign w_nr = w_diff[FRAC_BITS +: COORD_W] + r_c_re;
    assign w_ni = r_sx[FRAC_BITS-1 +: COORD_W] + r_c_im;

    assign w_k_next = (r_k == K_W'(COLOR_PERIOD - 1)) ? '0 : r_k + K_W'(1);
    assign w_rgb    = COLOR_LUT[r_k];

    assign o_sts.at_limit = (r_iter >= i_max_iter);
    assign o_sts.escape   = |w_mag[PROD_W-1:ESC_BIT];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_c_re <= i_c_re;
            r_c_im <= i_c_im;
            r_zr   <= '0;
            r_zi   <= '0;
            r_iter <= '0;
            r_k    <= '0;
        end
        if (i_cmd.mul) begin
            r_sr <= w_sr;
            r_si <= w_si;
            r_sx <= w_sx;
        end
        if (i_cmd.upd) begin
            r_zr   <= w_nr;
            r_zi   <= w_ni;
            r_iter <= r_iter + ITER_W'(1);
            r_k    <= w_k_next;
        end
        if (i_cmd.fin) begin
            r_esc <= i_cmd.fin_esc;
            if (i_cmd.fin_esc) begin
                r_red   <= w_rgb[2*CHAN_W +: CHAN_W];
                r_green <= w_rgb[CHAN_W +: CHAN_W];
                r_blue  <= w_rgb[0 +: CHAN_W];
            end else begin
                r_red   <= '0;
                r_green <= '0;
                r_blue  <= '0;
            end
        end
    end

    assign o_red        = r_red;
    assign o_green      = r_green;
    assign o_blue       = r_blue;
    assign o_escaped    = r_esc;
    assign o_iterations = r_iter;

endmodule
